// ===== hw/rtl/planar_to_packed_tile_pixels_assert.svh =====
`ifndef PLANAR_TO_PACKED_TILE_PIXELS_ASSERT_SVH
`define PLANAR_TO_PACKED_TILE_PIXELS_ASSERT_SVH

// checked outside reset
`define P2PT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define P2PT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/p2pt_pkg.sv =====
package p2pt_pkg;

	localparam int TILE_BYTES  = 128;
	localparam int TILE_ROWS   = 16;
	localparam int HALF_BYTES  = TILE_BYTES / 2;
	localparam int POS_W       = $clog2(TILE_BYTES);
	localparam int ROW_W       = $clog2(TILE_ROWS);
	localparam int ROW_PIXELS  = 16;
	localparam int PIXEL_IDX_W = $clog2(ROW_PIXELS);
	localparam int PIX_W       = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [1:0] LANE_LAST = 2'd3;

	typedef struct packed {
		logic [31:0] left;
		logic [31:0] right;
		logic        last;
	} row_job_t;

endpackage

// ===== hw/rtl/p2pt_front.sv =====
module p2pt_front #(
	parameter int DEPTH = p2pt_pkg::QUEUE_DEPTH,
	parameter int LVL_W = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 end_of_region,
	input  logic [LVL_W-1:0]     level,
	output logic                 push,
	output p2pt_pkg::row_job_t   push_job
);

	logic [p2pt_pkg::POS_W-1:0] pos_q;
	logic [23:0]                group_q;
	logic [31:0]                store_q [p2pt_pkg::TILE_ROWS];
	logic [p2pt_pkg::ROW_W-1:0] row;
	logic                       accept;
	logic                       in_right;
	logic                       row_end;
	logic [LVL_W:0]             need;

	logic        valid_s1;
	logic [31:0] left_s1;
	logic [31:0] right_s1;
	logic        last_s1;

	assign need     = {1'b0, level} + (LVL_W + 1)'(valid_s1);
	assign in_ready = need < (LVL_W + 1)'(DEPTH);
	assign accept   = in_valid && in_ready;
	assign row      = pos_q[2 +: p2pt_pkg::ROW_W];
	assign in_right = !pos_q[p2pt_pkg::POS_W-1];
	assign row_end  = !in_right && (pos_q[1:0] == p2pt_pkg::LANE_LAST);

	// right-half store, one 32-bit word per row, byte lanes written singly
	always_ff @(posedge clk) begin
		if (accept && in_right) begin
			store_q[row][pos_q[1:0]*8 +: 8] <= data_byte;
		end
		if (accept && row_end) begin
			right_s1 <= store_q[row];
			left_s1  <= {data_byte, group_q};
			last_s1  <= end_of_region;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			group_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept && row_end;
			if (accept) begin
				if (end_of_region) begin
					pos_q   <= '0;
					group_q <= '0;
				end else begin
					if (!in_right && !row_end) begin
						group_q[pos_q[1:0]*8 +: 8] <= data_byte;
					end
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

	assign push           = valid_s1;
	assign push_job.left  = left_s1;
	assign push_job.right = right_s1;
	assign push_job.last  = last_s1;

endmodule

// ===== hw/rtl/p2pt_queue.sv =====
module p2pt_queue #(
	parameter int DEPTH = p2pt_pkg::QUEUE_DEPTH,
	parameter int LVL_W = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  p2pt_pkg::row_job_t   push_job,
	input  logic                 pop,
	output logic                 head_valid,
	output p2pt_pkg::row_job_t   head_job,
	output logic [LVL_W-1:0]     level
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	p2pt_pkg::row_job_t entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [LVL_W-1:0]   level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   level_q <= level_q + 1'b1;
				2'b01:   level_q <= level_q - 1'b1;
				default: level_q <= level_q;
			endcase
		end
	end

	assign head_valid = level_q != '0;
	assign head_job   = entries_q[rd_q];
	assign level      = level_q;

endmodule

// ===== hw/rtl/p2pt_back.sv =====
module p2pt_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_valid,
	input  p2pt_pkg::row_job_t           head_job,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [p2pt_pkg::PIX_W-1:0]   pixel,
	output logic                         row_done,
	output logic                         region_done
);

	localparam logic [p2pt_pkg::PIXEL_IDX_W-1:0] LAST_PIX =
		p2pt_pkg::PIXEL_IDX_W'(p2pt_pkg::ROW_PIXELS - 1);

	logic [p2pt_pkg::PIXEL_IDX_W-1:0] k_q;
	logic                             out_valid_q;
	logic [p2pt_pkg::PIX_W-1:0]       pixel_q;
	logic                             row_done_q;
	logic                             region_done_q;
	logic                             load;
	logic                             final_pix;
	logic [31:0]                      src;
	logic [2:0]                       x;
	logic [p2pt_pkg::PIX_W-1:0]       pixel_d;

	assign load      = head_valid && (!out_valid_q || out_ready);
	assign final_pix = k_q == LAST_PIX;
	assign src       = k_q[p2pt_pkg::PIXEL_IDX_W-1] ? head_job.right : head_job.left;
	assign x         = k_q[2:0];
	// plane order 3,1,2,0 from msb down
	assign pixel_d   = {src[24 + x], src[8 + x], src[16 + x], src[x]};
	assign pop       = load && final_pix;

	always_ff @(posedge clk) begin
		if (load) begin
			pixel_q       <= pixel_d;
			row_done_q    <= final_pix;
			region_done_q <= final_pix && head_job.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				k_q         <= k_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel       = pixel_q;
	assign row_done    = row_done_q;
	assign region_done = region_done_q;

endmodule

// ===== hw/rtl/planar_to_packed_tile_pixels.sv =====
// channel   | handshake             | payload
// ----------+-----------------------+-----------------------------------
// in        | in_valid / in_ready   | data_byte[7:0], end_of_region
// out       | out_valid / out_ready | pixel[3:0], row_done, region_done
//
// Bytes are taken one per cycle while the row queue has room; each completed
// row yields 16 pixels, one per cycle while a row is queued and out_ready
// holds, through the single pixel output register.
// A row's first pixel passes the row register, queue and output register.
// Reset clears position, queue and output valid; the store needs no clear.
// A stalled output stops the back end only; the front keeps taking bytes
// until the queue is full.
module planar_to_packed_tile_pixels #(
	parameter int QUEUE_DEPTH = p2pt_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 data_byte,
	input  logic                       end_of_region,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [p2pt_pkg::PIX_W-1:0] pixel,
	output logic                       row_done,
	output logic                       region_done
);

	localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

	logic                 push;
	p2pt_pkg::row_job_t   push_job;
	logic                 pop;
	logic                 head_valid;
	p2pt_pkg::row_job_t   head_job;
	logic [LVL_W-1:0]     level;

	p2pt_front #(
		.DEPTH (QUEUE_DEPTH),
		.LVL_W (LVL_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_region (end_of_region),
		.level         (level),
		.push          (push),
		.push_job      (push_job)
	);

	p2pt_queue #(
		.DEPTH (QUEUE_DEPTH),
		.LVL_W (LVL_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job),
		.level      (level)
	);

	p2pt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel       (pixel),
		.row_done    (row_done),
		.region_done (region_done)
	);

endmodule

// ===== hw/rtl/p2pt_checker.sv =====
`include "planar_to_packed_tile_pixels_assert.svh"

module p2pt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic [7:0]                 data_byte,
	input logic                       end_of_region,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [p2pt_pkg::PIX_W-1:0] pixel,
	input logic                       row_done,
	input logic                       region_done
);

	logic in_seen;

	assign in_seen = in_valid && in_ready && (data_byte == data_byte) &&
		(end_of_region == end_of_region);

	`P2PT_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |-> !out_valid, "output valid during reset")

	`P2PT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pixel) && $stable(row_done) && $stable(region_done), "stalled output item changed")

	`P2PT_ASSERT(a_region_on_row, out_valid && region_done |-> row_done, "region end off a row end")

	`P2PT_ASSERT(a_row_burst, out_valid && out_ready && !row_done |=> out_valid, "gap inside a row burst")

	`P2PT_ASSERT(a_first_out_late, $rose(arst_n) && !in_seen |=> !out_valid, "output with no row taken")

endmodule

bind planar_to_packed_tile_pixels p2pt_checker u_p2pt_checker (.*);
